@@ hw/rtl/bfei_pkg.sv @@
// Shared constants, codes and types of the bit field extract/insert block.
// Depends on nothing; every other file but bfei_ram refers to it by scoped names.
package bfei_pkg;

  localparam int unsigned STORE_BYTES    = 256;
  localparam int unsigned ADDR_W         = $clog2(STORE_BYTES);
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned TOTAL_BITS     = STORE_BYTES * 8;
  localparam int unsigned START_W        = 11;
  localparam int unsigned LEN_W          = 7;
  localparam int unsigned SUM_W          = START_W + 1;
  localparam int unsigned WIN_BYTES      = MAX_FIELD_BITS / 8 + 1;
  localparam int unsigned WIN_W          = WIN_BYTES * 8;
  localparam int unsigned CNT_W          = $clog2(WIN_BYTES + 1);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  localparam logic [1:0] ORD_LE_LSB0 = 2'd0;
  localparam logic [1:0] ORD_LE_MSB0 = 2'd1;
  localparam logic [1:0] ORD_BE_LSB0 = 2'd2;
  localparam logic [1:0] ORD_BE_MSB0 = 2'd3;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_LOAD,
    KIND_READ,
    KIND_WRITE,
    KIND_ERR
  } bfei_kind_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  load_address;
    logic [7:0]  load_byte;
    logic [10:0] bit_start;
    logic [6:0]  field_len;
    logic [63:0] field_value;
  } bfei_req_t;

  typedef struct packed {
    logic [63:0] field_data;
    logic        range_error;
  } bfei_rsp_t;

  typedef struct packed {
    logic             capture;
    logic             load_wr;
    logic             res_init;
    logic             rd_en;
    logic [CNT_W-1:0] rd_off;
    logic             proc_en;
    logic [CNT_W-1:0] proc_j;
    logic             pack;
  } bfei_cmd_t;

  typedef struct packed {
    bfei_kind_e       kind;
    logic [CNT_W-1:0] nbytes;
  } bfei_sts_t;

endpackage

@@ hw/rtl/bit_field_extract_insert_core.sv @@
// Top level of the bit field extract/insert block.
// Joins the sequencer (bfei_ctrl) and the datapath (bfei_dp); uses bfei_pkg.
//
// Usage:
//   Request channel: drive req_i and raise start; the item is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   result has been shown.
//   Result channel: result_o is valid for exactly one cycle, marked by
//   result_valid_o. The receiver cannot stall it; one result per item.
//   Config channel: cfg_data_i sets the read bit/byte order when cfg_valid_i
//   is high; cfg_ready_o is always high. Write it only while busy is low.
// Sequence per item, from the accept edge to the strobe cycle:
//   load, rejected access, empty field, unused code: decode, then strobe.
//   field write: decode, a store read per byte with the modified byte written
//   back, then strobe; field read: the same byte reads, then pack, then strobe.
//   The field touches nbytes = 1..9 store bytes; the store is a single byte-wide
//   RAM, so the field is read or modified one byte per cycle. A new item is
//   accepted the cycle after the strobe.
// Reset clears the sequencer and sets the read order to le_lsb0. The store
// is not cleared; bytes are meaningful only once loaded or written.
module bit_field_extract_insert_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  bfei_pkg::bfei_req_t req_i,
  output logic                result_valid_o,
  output bfei_pkg::bfei_rsp_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i
);

  bfei_pkg::bfei_cmd_t cmd;
  bfei_pkg::bfei_sts_t sts;

  assign cfg_ready_o = 1'b1;

  bfei_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .rsp_valid_o (result_valid_o)
  );

  bfei_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (result_o)
  );

endmodule

@@ hw/rtl/bfei_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module bfei_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/bfei_ctrl.sv @@
// Sequencer of the bit field extract/insert block: accepts items, walks the
// bytes of a field and strobes the result. Uses bfei_pkg.
module bfei_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  bfei_pkg::bfei_sts_t sts_i,
  output bfei_pkg::bfei_cmd_t cmd_o,
  output logic               rsp_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RUN,
    ST_PACK,
    ST_RESP
  } state_e;

  state_e                     state_q;
  logic [bfei_pkg::CNT_W-1:0] cnt_q;
  logic [bfei_pkg::CNT_W-1:0] pj_q;
  logic                       pend_q;
  logic                       busy_q;
  logic                       rsp_valid_q;
  logic                       accept;
  logic                       issue;

  assign accept = start_i && !busy_q;
  assign issue  = (state_q == ST_RUN) && (cnt_q != sts_i.nbytes);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && accept;
    cmd_o.load_wr  = (state_q == ST_DECODE) && (sts_i.kind == bfei_pkg::KIND_LOAD);
    cmd_o.res_init = (state_q == ST_DECODE);
    cmd_o.rd_en    = issue;
    cmd_o.rd_off   = cnt_q;
    cmd_o.proc_en  = (state_q == ST_RUN) && pend_q;
    cmd_o.proc_j   = pj_q;
    cmd_o.pack     = (state_q == ST_PACK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pj_q        <= '0;
      pend_q      <= 1'b0;
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DECODE;
            busy_q  <= 1'b1;
          end
        end
        ST_DECODE: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
          if (sts_i.kind == bfei_pkg::KIND_READ || sts_i.kind == bfei_pkg::KIND_WRITE) begin
            state_q <= ST_RUN;
          end else begin
            state_q     <= ST_RESP;
            rsp_valid_q <= 1'b1;
          end
        end
        ST_RUN: begin
          cnt_q  <= cnt_q + bfei_pkg::CNT_W'(issue);
          pend_q <= issue;
          pj_q   <= cnt_q;
          if (!issue && pend_q) begin
            if (sts_i.kind == bfei_pkg::KIND_READ) begin
              state_q <= ST_PACK;
            end else begin
              state_q     <= ST_RESP;
              rsp_valid_q <= 1'b1;
            end
          end
        end
        ST_PACK: begin
          state_q     <= ST_RESP;
          rsp_valid_q <= 1'b1;
        end
        ST_RESP: begin
          state_q     <= ST_IDLE;
          rsp_valid_q <= 1'b0;
          busy_q      <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = busy_q;
  assign rsp_valid_o = rsp_valid_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |=> !rsp_valid_q)
    else $error("result strobe held longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> busy_q)
    else $error("result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> busy_q)
    else $error("item accepted but busy not raised");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= sts_i.nbytes))
    else $error("byte counter ran past field span");

  a_proc_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.proc_en |-> $past(cmd_o.rd_en))
    else $error("byte processed without a read issued");

endmodule

@@ hw/rtl/bfei_dp.sv @@
// Datapath of the bit field extract/insert block: item registers, byte store,
// field window accumulators and result packing. Uses bfei_pkg and bfei_ram.
module bfei_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_data_i,
  input  bfei_pkg::bfei_req_t req_i,
  input  bfei_pkg::bfei_cmd_t cmd_i,
  output bfei_pkg::bfei_sts_t sts_o,
  output bfei_pkg::bfei_rsp_t rsp_o
);

  bfei_pkg::bfei_req_t            req_q;
  bfei_pkg::bfei_rsp_t            rsp_q;
  logic [1:0]                     order_q;
  logic [bfei_pkg::WIN_BYTES-1:0][7:0] win_q;
  logic [bfei_pkg::WIN_W-1:0]     be_q;

  bfei_pkg::bfei_kind_e           kind;
  logic [2:0]                     ofs;
  logic [2:0]                     sh;
  logic [bfei_pkg::ADDR_W-1:0]    idx0;
  logic [bfei_pkg::LEN_W-1:0]     len;
  logic [bfei_pkg::SUM_W-1:0]     end_sum;
  logic [bfei_pkg::LEN_W-1:0]     olen;
  logic [bfei_pkg::LEN_W-1:0]     olen_m1;
  logic [bfei_pkg::CNT_W-1:0]     nbytes;
  logic [bfei_pkg::MAX_FIELD_BITS-1:0] lenmask;
  logic [bfei_pkg::WIN_BYTES-1:0][7:0] ins_val;
  logic [bfei_pkg::WIN_BYTES-1:0][7:0] ins_msk;

  logic                           first;
  logic                           last;
  logic [7:0]                     rd_byte;
  logic [7:0]                     t1;
  logic [7:0]                     tbyte;
  logic [7:0]                     wb_byte;

  logic                           ram_we;
  logic [bfei_pkg::ADDR_W-1:0]    ram_waddr;
  logic [7:0]                     ram_wdata;
  logic [bfei_pkg::ADDR_W-1:0]    ram_raddr;

  logic [bfei_pkg::WIN_W-1:0]     wv;
  logic [3:0]                     nprime;
  logic [3:0]                     rbits;
  logic [bfei_pkg::WIN_W-1:0]     packed_sel;
  logic [bfei_pkg::MAX_FIELD_BITS-1:0] packed_val;

  assign ofs     = req_q.bit_start[2:0];
  assign idx0    = req_q.bit_start[bfei_pkg::START_W-1:3];
  assign len     = req_q.field_len;
  assign end_sum = {1'b0, req_q.bit_start} + bfei_pkg::SUM_W'(len);
  assign olen    = bfei_pkg::LEN_W'(ofs) + len;
  assign olen_m1 = olen - bfei_pkg::LEN_W'(1);
  assign nbytes  = bfei_pkg::CNT_W'(olen_m1[bfei_pkg::LEN_W-1:3]) + bfei_pkg::CNT_W'(1);
  assign sh      = 3'd0 - olen[2:0];
  assign lenmask = ~({bfei_pkg::MAX_FIELD_BITS{1'b1}} << len);
  assign ins_val = bfei_pkg::WIN_W'(req_q.field_value & lenmask) << ofs;
  assign ins_msk = bfei_pkg::WIN_W'(lenmask) << ofs;

  always_comb begin
    kind = bfei_pkg::KIND_NONE;
    unique case (req_q.req_type)
      bfei_pkg::REQ_LOAD: begin
        if (32'(req_q.load_address) < bfei_pkg::STORE_BYTES) begin
          kind = bfei_pkg::KIND_LOAD;
        end else begin
          kind = bfei_pkg::KIND_ERR;
        end
      end
      bfei_pkg::REQ_READ, bfei_pkg::REQ_WRITE: begin
        if (len > bfei_pkg::LEN_W'(bfei_pkg::MAX_FIELD_BITS) ||
            end_sum > bfei_pkg::SUM_W'(bfei_pkg::TOTAL_BITS)) begin
          kind = bfei_pkg::KIND_ERR;
        end else if (len == '0) begin
          kind = bfei_pkg::KIND_NONE;
        end else if (req_q.req_type == bfei_pkg::REQ_READ) begin
          kind = bfei_pkg::KIND_READ;
        end else begin
          kind = bfei_pkg::KIND_WRITE;
        end
      end
      default: begin
        kind = bfei_pkg::KIND_NONE;
      end
    endcase
  end

  assign sts_o.kind   = kind;
  assign sts_o.nbytes = nbytes;

  assign first = (cmd_i.proc_j == '0);
  assign last  = (cmd_i.proc_j == nbytes - bfei_pkg::CNT_W'(1));

  always_comb begin
    t1    = rd_byte;
    tbyte = rd_byte;
    unique case (order_q)
      bfei_pkg::ORD_LE_MSB0: begin
        tbyte = last ? (rd_byte >> sh) : rd_byte;
      end
      bfei_pkg::ORD_BE_LSB0: begin
        t1    = first ? (rd_byte >> ofs) : rd_byte;
        tbyte = last ? (t1 & (8'hFF >> sh)) : t1;
      end
      bfei_pkg::ORD_LE_LSB0, bfei_pkg::ORD_BE_MSB0: begin
        tbyte = rd_byte;
      end
      default: begin
        tbyte = rd_byte;
      end
    endcase
  end

  assign wb_byte = (rd_byte & ~ins_msk[cmd_i.proc_j]) |
                   (ins_val[cmd_i.proc_j] & ins_msk[cmd_i.proc_j]);

  assign ram_we    = cmd_i.load_wr || (cmd_i.proc_en && kind == bfei_pkg::KIND_WRITE);
  assign ram_waddr = cmd_i.load_wr ? bfei_pkg::ADDR_W'(req_q.load_address)
                                   : idx0 + bfei_pkg::ADDR_W'(cmd_i.proc_j);
  assign ram_wdata = cmd_i.load_wr ? req_q.load_byte : wb_byte;
  assign ram_raddr = idx0 + bfei_pkg::ADDR_W'(cmd_i.rd_off);

  bfei_ram #(
    .WIDTH (8),
    .DEPTH (bfei_pkg::STORE_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (cmd_i.rd_en),
    .rd_addr_i (ram_raddr),
    .rd_data_o (rd_byte)
  );

  assign wv     = win_q;
  assign nprime = 4'd8 - {1'b0, ofs};
  assign rbits  = 4'd8 - {1'b0, sh};

  always_comb begin
    packed_sel = wv >> ofs;
    unique case (order_q)
      bfei_pkg::ORD_LE_LSB0: begin
        packed_sel = wv >> ofs;
      end
      bfei_pkg::ORD_LE_MSB0: begin
        packed_sel = ((wv >> 8) << nprime) | bfei_pkg::WIN_W'(wv[7:0] & (8'hFF >> ofs));
      end
      bfei_pkg::ORD_BE_LSB0: begin
        packed_sel = ((be_q >> 8) << rbits) | bfei_pkg::WIN_W'(be_q[7:0]);
      end
      bfei_pkg::ORD_BE_MSB0: begin
        packed_sel = be_q >> sh;
      end
      default: begin
        packed_sel = wv >> ofs;
      end
    endcase
  end

  assign packed_val = packed_sel[bfei_pkg::MAX_FIELD_BITS-1:0] & lenmask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= bfei_pkg::ORD_LE_LSB0;
    end else if (cfg_we_i) begin
      order_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
      win_q <= '0;
      be_q  <= '0;
    end else if (cmd_i.proc_en) begin
      win_q[cmd_i.proc_j] <= tbyte;
      be_q                <= {be_q[bfei_pkg::WIN_W-9:0], tbyte};
    end
    if (cmd_i.res_init) begin
      rsp_q.field_data  <= '0;
      rsp_q.range_error <= (kind == bfei_pkg::KIND_ERR);
    end else if (cmd_i.pack) begin
      rsp_q.field_data <= packed_val;
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ dv/bit_field_extract_insert_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of bit_field_extract_insert_core: drives load, read and write
// items over all read orders and checks every result against a built-in predictor.
// Depends on bfei_pkg and the RTL of the core only.
module bit_field_extract_insert_core_tb;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 210;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  bfei_pkg::bfei_req_t req_i;
  logic                result_valid_o;
  bfei_pkg::bfei_rsp_t result_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_data_i;

  bit_field_extract_insert_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  class bfei_field_checker;
    logic [7:0] store_img [bfei_pkg::STORE_BYTES];
    logic [1:0] order;
    bfei_pkg::bfei_rsp_t pending_rsp [$];
    int errors;
    int n_load, n_read, n_write, n_reject, n_unused;

    function new();
      order = bfei_pkg::ORD_LE_LSB0;
      errors = 0;
      n_load = 0; n_read = 0; n_write = 0; n_reject = 0; n_unused = 0;
      foreach (store_img[i]) store_img[i] = 8'h00;
    endfunction

    function void set_order(logic [1:0] v);
      order = v;
    endfunction

    function logic [63:0] byte_at(int idx);
      return (idx < bfei_pkg::STORE_BYTES) ? 64'(store_img[idx]) : 64'h0;
    endfunction

    function logic [63:0] low_mask(int r);
      return (r >= 8) ? 64'hFF : ((64'h1 << r) - 64'h1);
    endfunction

    function logic [63:0] extract_field(int s, int l);
      logic [63:0] v;
      logic [63:0] b;
      int idx, o, n, rem, p;
      v = '0;
      idx = s >> 3;
      o = s & 7;
      case (order)
        bfei_pkg::ORD_LE_LSB0: begin
          for (int k = 0; k < l; k++) begin
            p = s + k;
            b = byte_at(p >> 3);
            v = v | (((b >> p[2:0]) & 64'h1) << k);
          end
        end
        bfei_pkg::ORD_BE_MSB0: begin
          for (int k = 0; k < l; k++) begin
            p = s + k;
            b = byte_at(p >> 3);
            v = (v << 1) | ((b >> (3'd7 - p[2:0])) & 64'h1);
          end
        end
        bfei_pkg::ORD_BE_LSB0: begin
          rem = l;
          if (o != 0) begin
            n = 8 - o;
            v = byte_at(idx) >> o;
            if (l <= n) return v & low_mask(l);
            rem -= n;
            idx++;
          end
          while (rem >= 8) begin
            v = (v << 8) | byte_at(idx);
            idx++;
            rem -= 8;
          end
          if (rem != 0) v = (v << rem) | (byte_at(idx) & low_mask(rem));
        end
        default: begin
          n = 0;
          if (o != 0) begin
            n = 8 - o;
            v = byte_at(idx) & low_mask(n);
            idx++;
            if (l <= n) return v >> (n - l);
          end
          while (n + 8 <= l) begin
            v |= byte_at(idx) << n;
            idx++;
            n += 8;
          end
          if (l > n) v |= (byte_at(idx) >> (8 - (l - n))) << n;
        end
      endcase
      return v;
    endfunction

    function void insert_field(int s, int l, logic [63:0] value);
      int p;
      for (int k = 0; k < l; k++) begin
        p = s + k;
        if ((p >> 3) < bfei_pkg::STORE_BYTES) store_img[p >> 3][p & 7] = value[k];
      end
    endfunction

    function void note_request(bfei_pkg::bfei_req_t r);
      bfei_pkg::bfei_rsp_t rsp;
      int s, l;
      rsp = '0;
      s = int'(r.bit_start);
      l = int'(r.field_len);
      case (r.req_type)
        bfei_pkg::REQ_LOAD: begin
          store_img[r.load_address] = r.load_byte;
          n_load++;
        end
        bfei_pkg::REQ_READ, bfei_pkg::REQ_WRITE: begin
          if (l > bfei_pkg::MAX_FIELD_BITS || s + l > bfei_pkg::TOTAL_BITS) begin
            rsp.range_error = 1'b1;
            n_reject++;
          end else if (r.req_type == bfei_pkg::REQ_READ) begin
            rsp.field_data = extract_field(s, l);
            n_read++;
          end else begin
            insert_field(s, l, r.field_value);
            n_write++;
          end
        end
        default: n_unused++;
      endcase
      pending_rsp.push_back(rsp);
    endfunction

    function void check_response(bfei_pkg::bfei_rsp_t got);
      bfei_pkg::bfei_rsp_t want;
      if (pending_rsp.size() == 0) begin
        $error("result with no item outstanding: field_data %h range_error %b",
               got.field_data, got.range_error);
        errors++;
        return;
      end
      want = pending_rsp.pop_front();
      if (got.field_data !== want.field_data) begin
        $error("field_data expected %h actual %h", want.field_data, got.field_data);
        errors++;
      end
      if (got.range_error !== want.range_error) begin
        $error("range_error expected %b actual %b", want.range_error, got.range_error);
        errors++;
      end
    endfunction
  endclass

  bfei_field_checker board = new();
  bit written_map [bfei_pkg::STORE_BYTES];
  int cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) board.check_response(result_o);
  end

  function automatic bfei_pkg::bfei_req_t rand_req();
    bfei_pkg::bfei_req_t r;
    r.req_type     = 2'($urandom_range(3));
    r.load_address = 8'($urandom);
    r.load_byte    = 8'($urandom);
    r.bit_start    = 11'($urandom);
    r.field_len    = 7'($urandom);
    r.field_value  = {$urandom, $urandom};
    return r;
  endfunction

  function automatic bfei_pkg::bfei_req_t load_req(int addr, logic [7:0] val);
    bfei_pkg::bfei_req_t r;
    r = rand_req();
    r.req_type = bfei_pkg::REQ_LOAD;
    r.load_address = 8'(addr);
    r.load_byte = val;
    return r;
  endfunction

  function automatic bfei_pkg::bfei_req_t field_req(logic [1:0] kind, int s, int l,
                                                    logic [63:0] val);
    bfei_pkg::bfei_req_t r;
    r = rand_req();
    r.req_type = kind;
    r.bit_start = 11'(s);
    r.field_len = 7'(l);
    r.field_value = val;
    return r;
  endfunction

  function automatic int first_unwritten(int s, int l);
    for (int b = s >> 3; b <= (s + l - 1) >> 3; b++) begin
      if (!written_map[b]) return b;
    end
    return -1;
  endfunction

  function automatic bfei_pkg::bfei_req_t random_item();
    bfei_pkg::bfei_req_t r;
    int pick, s, l, hole;
    r = rand_req();
    pick = $urandom_range(99);
    if (pick < 15) begin
      r.req_type = bfei_pkg::REQ_LOAD;
    end else if (pick < 20) begin
      r.req_type = REQ_UNUSED;
    end else if (pick < 28) begin
      r.req_type = $urandom_range(1) ? bfei_pkg::REQ_READ : bfei_pkg::REQ_WRITE;
      if ($urandom_range(1)) begin
        r.field_len = 7'($urandom_range(127, bfei_pkg::MAX_FIELD_BITS + 1));
      end else begin
        l = $urandom_range(bfei_pkg::MAX_FIELD_BITS, 2);
        r.field_len = 7'(l);
        r.bit_start = 11'($urandom_range(bfei_pkg::TOTAL_BITS - 1,
                                         bfei_pkg::TOTAL_BITS + 1 - l));
      end
    end else if (pick < 30) begin
      r.req_type = $urandom_range(1) ? bfei_pkg::REQ_READ : bfei_pkg::REQ_WRITE;
      r.field_len = '0;
    end else begin
      r.req_type = (pick < 65) ? bfei_pkg::REQ_READ : bfei_pkg::REQ_WRITE;
      case ($urandom_range(3))
        0:       l = bfei_pkg::MAX_FIELD_BITS;
        1:       l = $urandom_range(8, 1);
        default: l = $urandom_range(bfei_pkg::MAX_FIELD_BITS, 1);
      endcase
      s = ($urandom_range(9) == 0) ? bfei_pkg::TOTAL_BITS - l
                                   : $urandom_range(bfei_pkg::TOTAL_BITS - l);
      r.bit_start = 11'(s);
      r.field_len = 7'(l);
      hole = first_unwritten(s, l);
      if (hole >= 0) r = load_req(hole, 8'($urandom));
    end
    return r;
  endfunction

  task automatic issue(input bfei_pkg::bfei_req_t r, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (r.req_type == bfei_pkg::REQ_LOAD) written_map[r.load_address] = 1'b1;
    board.note_request(r);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (board.pending_rsp.size() != 0 || busy);
  endtask

  task automatic set_read_order(input logic [1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_order(v);
  endtask

  initial begin
    logic [1:0] phase_order [8];
    int idle_pct;
    phase_order = '{bfei_pkg::ORD_LE_MSB0, bfei_pkg::ORD_BE_LSB0,
                    bfei_pkg::ORD_BE_MSB0, bfei_pkg::ORD_LE_LSB0,
                    bfei_pkg::ORD_BE_MSB0, bfei_pkg::ORD_LE_MSB0,
                    bfei_pkg::ORD_LE_LSB0, bfei_pkg::ORD_BE_LSB0};
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_read_order(bfei_pkg::ORD_LE_LSB0);

    issue(load_req(0, 8'h00), 0);
    issue(load_req(1, 8'hFF), 0);
    for (int a = 2; a < 9; a++) issue(load_req(a, 8'($urandom)), 0);
    issue(load_req(254, 8'h00), 0);
    issue(load_req(255, 8'hFF), 0);
    issue(field_req(bfei_pkg::REQ_READ, 0, 64, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 5, 64, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 3, 5, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 2047, 1, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 2032, 16, '0), 0);
    issue(field_req(bfei_pkg::REQ_WRITE, 7, 64, '1), 0);
    issue(field_req(bfei_pkg::REQ_WRITE, 0, 1, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 0, 64, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 2047, 2, '0), 0);
    issue(field_req(bfei_pkg::REQ_WRITE, 2000, 64, '1), 0);
    issue(field_req(bfei_pkg::REQ_READ, 10, 127, '0), 0);
    issue(field_req(bfei_pkg::REQ_READ, 0, 0, '0), 0);
    issue(field_req(bfei_pkg::REQ_WRITE, 9, 0, '1), 0);
    issue(field_req(REQ_UNUSED, 0, 8, '1), 0);
    issue(field_req(bfei_pkg::REQ_WRITE, 2040, 8, 64'h5A), 0);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      set_read_order(phase_order[ph]);
      case (ph % 4)
        1:       idle_pct = 55;
        3:       idle_pct = 15;
        default: idle_pct = 0;
      endcase
      repeat (PHASE_ITEMS) issue(random_item(), idle_pct);
    end

    start <= 1'b0;
    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d loads, %0d reads, %0d writes, %0d rejected accesses,",
             board.n_load, board.n_read, board.n_write, board.n_reject);
    $display("%0d unused codes, across all four read orders with sender gaps of 0, 15, 55 pct",
             board.n_unused);
    if (board.errors == 0 && board.pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
